// ===== rtl/xcfr_pkg.sv =====
// Package for the XOR-checked frame receiver.
// Holds the request opcodes, payload widths and framing constants.
// No dependencies.
`default_nettype none

package xcfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 5;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_t;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam byte_t RESTART_BYTE = 8'hFF;
  localparam pos_t  HEADER_POS   = 5'd2;
  localparam pos_t  LEN_BIAS     = 5'd4;
  localparam pos_t  LEN_UNKNOWN  = 5'd0;

endpackage : xcfr_pkg

`default_nettype wire

// ===== rtl/xcfr_if.sv =====
// Channel interfaces for the XOR-checked frame receiver.
// xcfr_in_if carries received-byte requests, xcfr_out_if carries results.
// Depends on xcfr_pkg.
`default_nettype none

interface xcfr_in_if
  import xcfr_pkg::*;
;
  logic  valid;
  logic  ready;
  op_t   op;
  byte_t rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface : xcfr_in_if

interface xcfr_out_if
  import xcfr_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t byte_out;
  pos_t  position;
  logic  frame_done;
  logic  xor_ok;
  logic  aborted;

  modport source (output valid, output byte_out, output position, output frame_done,
                  output xor_ok, output aborted, input ready);
  modport sink   (input valid, input byte_out, input position, input frame_done,
                  input xor_ok, input aborted, output ready);
endinterface : xcfr_out_if

`default_nettype wire

// ===== rtl/xor_checked_frame_receiver.sv =====
// Top level of the XOR-checked frame receiver.
// Tracks frame position, length and running XOR; one result per request.
// Depends on xcfr_pkg and the channel interfaces in xcfr_if.sv.
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------------------
//   in_ch    | sink      | op, rx_byte
//   out_ch   | source    | byte_out, position, frame_done, xor_ok, aborted
//
// The frame state and the result register are both loaded on the edge that accepts a
// request, so a new request is taken every cycle unless a held result drops in_ch.ready.
// The result appears in the cycle after acceptance and holds until taken.
// in_ch.ready stays high while the result register is empty or being drained.
// Synchronous active-low reset empties the result register and clears the frame state.
`default_nettype none

module xor_checked_frame_receiver
  import xcfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  xcfr_in_if.sink    in_ch,
  xcfr_out_if.source out_ch
);

  pos_t  byte_pos_r, byte_pos_nxt;
  pos_t  frame_len_r, frame_len_nxt;
  byte_t xor_acc_r, xor_acc_nxt;

  logic  out_valid_r, out_valid_nxt;
  byte_t byte_out_r, byte_out_nxt;
  pos_t  position_r, position_nxt;
  logic  frame_done_r, frame_done_nxt;
  logic  xor_ok_r, xor_ok_nxt;
  logic  aborted_r, aborted_nxt;

  logic  accept;
  logic  restart;
  pos_t  pos;
  pos_t  pos_inc;
  byte_t acc_base;
  logic  is_header;
  logic  is_end;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // A restart byte pulls its own position back to zero before it is classified.
  assign restart   = (in_ch.rx_byte == RESTART_BYTE);
  assign pos       = restart ? '0 : byte_pos_r;
  assign acc_base  = restart ? '0 : xor_acc_r;
  assign pos_inc   = pos + pos_t'(1);
  assign is_header = (pos == HEADER_POS);
  assign is_end    = !is_header && (frame_len_r != LEN_UNKNOWN) && (pos_inc == frame_len_r);

  always_comb begin
    byte_pos_nxt   = byte_pos_r;
    frame_len_nxt  = frame_len_r;
    xor_acc_nxt    = xor_acc_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    byte_out_nxt   = byte_out_r;
    position_nxt   = position_r;
    frame_done_nxt = frame_done_r;
    xor_ok_nxt     = xor_ok_r;
    aborted_nxt    = aborted_r;

    if (accept) begin
      out_valid_nxt = 1'b1;
      unique case (in_ch.op)
        OP_TIMEOUT: begin
          byte_pos_nxt   = '0;
          frame_len_nxt  = LEN_UNKNOWN;
          xor_acc_nxt    = '0;
          byte_out_nxt   = '0;
          position_nxt   = '0;
          frame_done_nxt = 1'b0;
          xor_ok_nxt     = 1'b0;
          aborted_nxt    = 1'b1;
        end
        OP_BYTE: begin
          byte_out_nxt   = in_ch.rx_byte;
          position_nxt   = pos;
          frame_done_nxt = is_end;
          xor_ok_nxt     = is_end && (acc_base == in_ch.rx_byte);
          aborted_nxt    = 1'b0;
          priority if (is_end) begin
            byte_pos_nxt  = '0;
            frame_len_nxt = LEN_UNKNOWN;
            xor_acc_nxt   = '0;
          end else begin
            byte_pos_nxt = pos_inc;
            if (is_header) begin
              frame_len_nxt = pos_t'(in_ch.rx_byte[3:0]) + LEN_BIAS;
              xor_acc_nxt   = in_ch.rx_byte;
            end else if (pos > HEADER_POS) begin
              xor_acc_nxt = acc_base ^ in_ch.rx_byte;
            end else begin
              xor_acc_nxt = acc_base;
            end
          end
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ch.ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      byte_pos_r  <= '0;
      frame_len_r <= LEN_UNKNOWN;
      xor_acc_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      byte_pos_r  <= byte_pos_nxt;
      frame_len_r <= frame_len_nxt;
      xor_acc_r   <= xor_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_out_r   <= byte_out_nxt;
    position_r   <= position_nxt;
    frame_done_r <= frame_done_nxt;
    xor_ok_r     <= xor_ok_nxt;
    aborted_r    <= aborted_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.byte_out   = byte_out_r;
  assign out_ch.position   = position_r;
  assign out_ch.frame_done = frame_done_r;
  assign out_ch.xor_ok     = xor_ok_r;
  assign out_ch.aborted    = aborted_r;

endmodule : xor_checked_frame_receiver

`default_nettype wire

// ===== test/tb_xor_checked_frame_receiver.sv =====
// Testbench for the XOR-checked frame receiver: predicts every echoed byte and
// compares it field by field. Needs rtl/xcfr_pkg.sv, rtl/xcfr_if.sv and the top level.
// Directed frames first, then random frames, broken frames and noise.
`timescale 1ns / 1ps

module tb_xor_checked_frame_receiver;
  import xcfr_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_OFF_LEN  = 48;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    byte_t byte_out;
    pos_t  position;
    logic  frame_done;
    logic  xor_ok;
    logic  aborted;
  } echo_t;

  // Tracks the frame state of the block and holds the echoes still to come.
  class frame_echo_model;
    pos_t  next_pos;
    pos_t  frame_len;
    byte_t running_xor;
    echo_t expected_echoes[$];
    int    mismatches;
    int    good_frames;
    int    bad_frames;
    int    timeouts;
    int    restarts;

    function new();
      next_pos    = '0;
      frame_len   = LEN_UNKNOWN;
      running_xor = '0;
    endfunction

    function int outstanding();
      return expected_echoes.size();
    endfunction

    function void note_request(op_t op, byte_t b);
      echo_t e;
      pos_t  p;
      e = '0;
      if (op == OP_TIMEOUT) begin
        e.aborted   = 1'b1;
        next_pos    = '0;
        frame_len   = LEN_UNKNOWN;
        running_xor = '0;
        timeouts++;
      end else begin
        if (b == RESTART_BYTE) begin
          next_pos    = '0;
          running_xor = '0;
          restarts++;
        end
        p          = next_pos;
        e.byte_out = b;
        e.position = p;
        if (p == HEADER_POS) begin
          frame_len   = pos_t'(b[3:0]) + LEN_BIAS;
          running_xor = b;
        end else if (frame_len != LEN_UNKNOWN && pos_t'(p + 5'd1) == frame_len) begin
          e.frame_done = 1'b1;
          e.xor_ok     = (running_xor == b);
        end else if (p > HEADER_POS) begin
          running_xor = running_xor ^ b;
        end
        if (e.frame_done) begin
          if (e.xor_ok) good_frames++;
          else bad_frames++;
          next_pos    = '0;
          frame_len   = LEN_UNKNOWN;
          running_xor = '0;
        end else begin
          next_pos = p + 5'd1;
        end
      end
      expected_echoes.push_back(e);
    endfunction

    function void check_echo(echo_t got);
      echo_t want;
      if (expected_echoes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result byte=%h pos=%0d done=%b ok=%b aborted=%b",
                   $time, got.byte_out, got.position, got.frame_done, got.xor_ok,
                   got.aborted);
        return;
      end
      want = expected_echoes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: byte/pos/done/ok/aborted expected %h/%0d/%b/%b/%b got %h/%0d/%b/%b/%b",
                   $time, want.byte_out, want.position, want.frame_done, want.xor_ok,
                   want.aborted, got.byte_out, got.position, got.frame_done, got.xor_ok,
                   got.aborted);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  xcfr_in_if  in_ch();
  xcfr_out_if out_ch();

  xor_checked_frame_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_echo_model tracker = new();

  int requests_sent;
  int burst_left;
  int quiet_cycles;
  int hold_offs;
  bit hold_off_req;
  bit force_restart;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: a stall pattern picked at random from four modes, plus a long hold-off
  // on request while the sender keeps the block busy.
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_LEN - 1) @(negedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= (cyc % 7 != 0) && (cyc % 11 != 3);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        cyc++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_echo('{out_ch.byte_out, out_ch.position, out_ch.frame_done,
                           out_ch.xor_ok, out_ch.aborted});
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sends one request, with a random gap in front of it when a burst runs out.
  task automatic send_request(op_t op, byte_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid   <= 1'b0;
        in_ch.op      <= op_t'($urandom_range(0, 1));
        in_ch.rx_byte <= byte_t'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_request(op, b);
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  function automatic byte_t plain_byte();
    return byte_t'($urandom_range(0, 254));
  endfunction

  // One frame with random content. A cut position below the frame length ends it
  // there, by a timeout or silently; the checksum may be corrupted on purpose.
  task automatic send_frame(bit corrupt, bit lead_restart, int cut_at, bit cut_by_timeout);
    byte_t hdr;
    byte_t sum;
    byte_t b;
    int    len;
    hdr = plain_byte();
    len = int'(hdr[3:0]) + int'(LEN_BIAS);
    sum = '0;
    for (int i = 0; i < len; i++) begin
      if (i == cut_at) begin
        if (cut_by_timeout) send_request(OP_TIMEOUT, byte_t'($urandom));
        return;
      end
      if (i == 0 && lead_restart) b = RESTART_BYTE;
      else if (i == int'(HEADER_POS)) b = hdr;
      else if (i == len - 1) b = corrupt ? sum ^ byte_t'($urandom_range(1, 255)) : sum;
      else b = plain_byte();
      if (i >= int'(HEADER_POS)) sum = sum ^ b;
      send_request(OP_BYTE, b);
    end
  endtask

  initial begin
    int r;
    bit did_hold;
    bit did_drain;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_BYTE;
    in_ch.rx_byte = '0;
    rst_n         = 1'b0;
    burst_left    = 0;
    did_hold      = 1'b0;
    did_drain     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Timeout with no frame in progress.
    send_request(OP_TIMEOUT, 8'hFF);
    // Shortest frame, all zeros, checksum good.
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'h00);
    // Shortest frame with a wrong checksum.
    send_request(OP_BYTE, 8'hFE);
    send_request(OP_BYTE, 8'h80);
    send_request(OP_BYTE, 8'h30);
    send_request(OP_BYTE, 8'h31);
    // Restart byte before the header, which starts a five byte frame.
    send_request(OP_BYTE, 8'h12);
    send_request(OP_BYTE, RESTART_BYTE);
    send_request(OP_BYTE, 8'h55);
    send_request(OP_BYTE, 8'h81);
    send_request(OP_BYTE, 8'h80);
    send_request(OP_BYTE, 8'h01);
    // Timeout after two leading bytes, before the header, then one after a header.
    send_request(OP_BYTE, 8'hAA);
    send_request(OP_BYTE, 8'h7F);
    send_request(OP_TIMEOUT, 8'h00);
    send_request(OP_BYTE, 8'h01);
    send_request(OP_BYTE, 8'h02);
    send_request(OP_BYTE, 8'h4F);
    send_request(OP_TIMEOUT, 8'hA5);
    wait_for_drain();

    while (requests_sent < RANDOM_ITEMS) begin
      if (!did_hold && requests_sent > RANDOM_ITEMS / 3) begin
        // Keep offering back to back while the receiver holds off.
        did_hold     = 1'b1;
        hold_off_req = 1'b1;
        burst_left   = HOLD_OFF_LEN + 20;
      end
      if (!did_drain && requests_sent > 2 * RANDOM_ITEMS / 3) begin
        did_drain = 1'b1;
        wait_for_drain();
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_frame($urandom_range(0, 5) == 0, force_restart || $urandom_range(0, 7) == 0,
                   -1, 1'b0);
        force_restart = 1'b0;
      end else if (r < 78) begin
        send_frame(1'b0, force_restart, $urandom_range(0, 18), 1'b1);
        force_restart = 1'b0;
      end else if (r < 90) begin
        send_frame(1'b0, force_restart, $urandom_range(1, 18), 1'b0);
        force_restart = 1'b1;
      end else begin
        repeat ($urandom_range(1, 6))
          send_request(($urandom_range(0, 5) == 0) ? OP_TIMEOUT : OP_BYTE, byte_t'($urandom));
      end
    end

    wait_for_drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d requests: %0d good frames, %0d bad checksums, %0d timeouts,",
             requests_sent, tracker.good_frames, tracker.bad_frames, tracker.timeouts);
    $display("%0d restart bytes, %0d long receiver hold-offs, %0d mismatches.",
             tracker.restarts, hold_offs, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule : tb_xor_checked_frame_receiver
